// File: rtl/sdci_pkg.sv
// Shared types, codes and constants for the SD/MMC card init sequencer.
package sdci_pkg;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] MMC_LIMIT_RST = 8'd15;
  localparam logic [7:0] SD_LIMIT_RST  = 8'd150;

  localparam logic [31:0] MMC_OCR_ARG   = 32'h00ff_c000;
  localparam logic [31:0] MMC_OCR_READY = 32'h80ff_c000;
  localparam logic [31:0] SD_OCR_ARG    = 32'h00ff_8000;
  localparam logic [31:0] SD_OCR_READY  = 32'h80ff_8000;
  localparam logic [31:0] MMC_RCA_ARG   = 32'h0001_0000;
  localparam logic [31:0] SD_BUS4_ARG   = 32'h0000_0002;
  localparam logic [15:0] MMC_RCA       = 16'h0001;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_SEND_OP  = 6'd1;
  localparam logic [5:0] CMD_ALL_CID  = 6'd2;
  localparam logic [5:0] CMD_SET_RCA  = 6'd3;
  localparam logic [5:0] CMD_BUS_WID  = 6'd6;
  localparam logic [5:0] CMD_SELECT   = 6'd7;
  localparam logic [5:0] CMD_SD_OP    = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;

  typedef enum logic [0:0] {
    CFG_MMC_LIMIT = 1'b0,
    CFG_SD_LIMIT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_DONE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ACT_ISSUE = 2'd0,
    ACT_OK    = 2'd1,
    ACT_FAIL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CLK_IDENT  = 2'd0,
    CLK_MMC    = 2'd1,
    CLK_SD     = 2'd2
  } clk_mode_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_GO_IDLE   = 4'd1,
    PH_MMC_OCR   = 4'd2,
    PH_SD_APP    = 4'd3,
    PH_SD_OCR    = 4'd4,
    PH_CID       = 4'd5,
    PH_RCA       = 4'd6,
    PH_SELECT    = 4'd7,
    PH_BUS_APP   = 4'd8,
    PH_BUS_WIDTH = 4'd9
  } phase_t;

  typedef struct packed {
    logic        opcode;
    logic        timed_out;
    logic [31:0] response;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic        wait_response;
    logic        long_response;
    logic        delay_first;
    logic        is_mmc;
    logic [15:0] card_address;
    logic [1:0]  clock_mode;
    logic        wide_bus;
  } result_t;

endpackage

// File: rtl/sdci_in_stage.sv
// Input register stage: holds one accepted event until the sequencer takes it.
module sdci_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sdci_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           step,
  output logic                           item_valid,
  output sdci_pkg::item_t                item
);

  logic            valid_r;
  logic            valid_nxt;
  sdci_pkg::item_t item_r;

  assign in_tready = !valid_r || step;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.opcode    <= in_tuser;
      item_r.timed_out <= in_tdata[0];
      item_r.response  <= in_tdata[32:1];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/sdci_seq.sv
// Sequencer state, limit registers and the per-event decision logic.
module sdci_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [sdci_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            step,
  input  sdci_pkg::item_t                 item,
  output sdci_pkg::result_t               res
);

  logic [7:0]         mmc_lim_r;
  logic [7:0]         sd_lim_r;
  sdci_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               mmc_r, mmc_nxt;
  logic [15:0]        rca_r, rca_nxt;
  logic [1:0]         clk_sel_r, clk_sel_nxt;
  logic               fin_r, fin_nxt;
  sdci_pkg::action_t  act;
  logic [7:0]         cnt_inc;
  logic               ocr_ok_mmc;
  logic               ocr_ok_sd;
  logic [31:0]        addr_arg;

  assign cfg_ready  = 1'b1;
  assign cnt_inc    = cnt_r + 8'd1;
  assign ocr_ok_mmc = !item.timed_out && (item.response == sdci_pkg::MMC_OCR_READY);
  assign ocr_ok_sd  = !item.timed_out && (item.response == sdci_pkg::SD_OCR_READY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmc_lim_r <= sdci_pkg::MMC_LIMIT_RST;
      sd_lim_r  <= sdci_pkg::SD_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sdci_pkg::cfg_idx_t'(cfg_index))
        sdci_pkg::CFG_MMC_LIMIT: mmc_lim_r <= cfg_data;
        sdci_pkg::CFG_SD_LIMIT:  sd_lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sdci_pkg::PH_IDLE;
      cnt_r     <= 8'd0;
      mmc_r     <= 1'b0;
      rca_r     <= 16'd0;
      clk_sel_r <= sdci_pkg::CLK_IDENT;
      fin_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      mmc_r     <= mmc_nxt;
      rca_r     <= rca_nxt;
      clk_sel_r <= clk_sel_nxt;
      fin_r     <= fin_nxt;
    end
  end

  // next state and transaction kind
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    mmc_nxt     = mmc_r;
    rca_nxt     = rca_r;
    clk_sel_nxt = clk_sel_r;
    fin_nxt     = fin_r;
    act         = sdci_pkg::ACT_NONE;
    if (item.opcode == sdci_pkg::OP_START) begin
      priority if (fin_r) begin
        act = sdci_pkg::ACT_OK;
      end else if (phase_r != sdci_pkg::PH_IDLE) begin
        act = sdci_pkg::ACT_NONE;
      end else begin
        rca_nxt     = 16'd0;
        clk_sel_nxt = sdci_pkg::CLK_IDENT;
        cnt_nxt     = 8'd0;
        phase_nxt   = sdci_pkg::PH_GO_IDLE;
        act         = sdci_pkg::ACT_ISSUE;
      end
    end else begin
      unique case (phase_r)
        sdci_pkg::PH_GO_IDLE: begin
          cnt_nxt = 8'd0;
          priority if (mmc_lim_r != 8'd0) begin
            phase_nxt = sdci_pkg::PH_MMC_OCR;
            act       = sdci_pkg::ACT_ISSUE;
          end else if (sd_lim_r == 8'd0) begin
            phase_nxt = sdci_pkg::PH_IDLE;
            act       = sdci_pkg::ACT_FAIL;
          end else begin
            phase_nxt = sdci_pkg::PH_SD_APP;
            act       = sdci_pkg::ACT_ISSUE;
          end
        end
        sdci_pkg::PH_MMC_OCR: begin
          priority if (ocr_ok_mmc) begin
            mmc_nxt   = 1'b1;
            phase_nxt = sdci_pkg::PH_CID;
            act       = sdci_pkg::ACT_ISSUE;
          end else if (cnt_inc < mmc_lim_r) begin
            cnt_nxt = cnt_inc;
            act     = sdci_pkg::ACT_ISSUE;
          end else if (sd_lim_r == 8'd0) begin
            cnt_nxt   = 8'd0;
            phase_nxt = sdci_pkg::PH_IDLE;
            act       = sdci_pkg::ACT_FAIL;
          end else begin
            cnt_nxt   = 8'd0;
            phase_nxt = sdci_pkg::PH_SD_APP;
            act       = sdci_pkg::ACT_ISSUE;
          end
        end
        sdci_pkg::PH_SD_APP: begin
          phase_nxt = sdci_pkg::PH_SD_OCR;
          act       = sdci_pkg::ACT_ISSUE;
        end
        sdci_pkg::PH_SD_OCR: begin
          priority if (ocr_ok_sd) begin
            mmc_nxt   = 1'b0;
            phase_nxt = sdci_pkg::PH_CID;
            act       = sdci_pkg::ACT_ISSUE;
          end else if (cnt_inc < sd_lim_r) begin
            cnt_nxt   = cnt_inc;
            phase_nxt = sdci_pkg::PH_SD_APP;
            act       = sdci_pkg::ACT_ISSUE;
          end else begin
            cnt_nxt   = cnt_inc;
            phase_nxt = sdci_pkg::PH_IDLE;
            act       = sdci_pkg::ACT_FAIL;
          end
        end
        sdci_pkg::PH_CID: begin
          act = sdci_pkg::ACT_ISSUE;
          if (!item.timed_out) begin
            phase_nxt = sdci_pkg::PH_RCA;
          end
        end
        sdci_pkg::PH_RCA: begin
          act = sdci_pkg::ACT_ISSUE;
          if (!item.timed_out) begin
            phase_nxt = sdci_pkg::PH_SELECT;
            if (mmc_r) begin
              rca_nxt     = sdci_pkg::MMC_RCA;
              clk_sel_nxt = sdci_pkg::CLK_MMC;
            end else begin
              rca_nxt     = item.response[31:16];
              clk_sel_nxt = sdci_pkg::CLK_SD;
            end
          end
        end
        sdci_pkg::PH_SELECT: begin
          act = sdci_pkg::ACT_ISSUE;
          if (!item.timed_out) begin
            phase_nxt = sdci_pkg::PH_BUS_APP;
          end
        end
        sdci_pkg::PH_BUS_APP: begin
          phase_nxt = sdci_pkg::PH_BUS_WIDTH;
          act       = sdci_pkg::ACT_ISSUE;
        end
        sdci_pkg::PH_BUS_WIDTH: begin
          if (item.timed_out) begin
            phase_nxt = sdci_pkg::PH_BUS_APP;
            act       = sdci_pkg::ACT_ISSUE;
          end else begin
            phase_nxt = sdci_pkg::PH_IDLE;
            fin_nxt   = 1'b1;
            act       = sdci_pkg::ACT_OK;
          end
        end
        default: begin
          phase_nxt = sdci_pkg::PH_IDLE;
          act       = sdci_pkg::ACT_NONE;
        end
      endcase
    end
  end

  // command fields follow from the phase being entered
  assign addr_arg = {rca_nxt, 16'd0};

  always_comb begin
    res               = '0;
    res.action        = act;
    res.is_mmc        = mmc_nxt;
    res.card_address  = rca_nxt;
    res.clock_mode    = clk_sel_nxt;
    res.wide_bus      = !mmc_nxt && (fin_nxt || phase_nxt == sdci_pkg::PH_BUS_APP ||
                                     phase_nxt == sdci_pkg::PH_BUS_WIDTH);
    if (act == sdci_pkg::ACT_ISSUE) begin
      res.wait_response = 1'b1;
      unique case (phase_nxt)
        sdci_pkg::PH_GO_IDLE: begin
          res.cmd_index     = sdci_pkg::CMD_GO_IDLE;
          res.wait_response = 1'b0;
        end
        sdci_pkg::PH_MMC_OCR: begin
          res.cmd_index = sdci_pkg::CMD_SEND_OP;
          res.argument  = sdci_pkg::MMC_OCR_ARG;
        end
        sdci_pkg::PH_SD_APP: begin
          res.cmd_index   = sdci_pkg::CMD_APP;
          res.argument    = addr_arg;
          res.delay_first = (phase_r == sdci_pkg::PH_SD_OCR);
        end
        sdci_pkg::PH_SD_OCR: begin
          res.cmd_index = sdci_pkg::CMD_SD_OP;
          res.argument  = sdci_pkg::SD_OCR_ARG;
        end
        sdci_pkg::PH_CID: begin
          res.cmd_index     = sdci_pkg::CMD_ALL_CID;
          res.long_response = 1'b1;
        end
        sdci_pkg::PH_RCA: begin
          res.cmd_index = sdci_pkg::CMD_SET_RCA;
          res.argument  = mmc_nxt ? sdci_pkg::MMC_RCA_ARG : 32'd0;
        end
        sdci_pkg::PH_SELECT: begin
          res.cmd_index = sdci_pkg::CMD_SELECT;
          res.argument  = addr_arg;
        end
        sdci_pkg::PH_BUS_APP: begin
          res.cmd_index = sdci_pkg::CMD_APP;
          res.argument  = addr_arg;
        end
        sdci_pkg::PH_BUS_WIDTH: begin
          res.cmd_index = sdci_pkg::CMD_BUS_WID;
          res.argument  = mmc_nxt ? 32'd0 : sdci_pkg::SD_BUS4_ARG;
        end
        default: begin
          res.wait_response = 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/sdci_out_stage.sv
// Output register stage: holds one result until the downstream takes it.
module sdci_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  input  sdci_pkg::result_t               res,
  output logic                            step,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sdci_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser
);

  logic              valid_r;
  sdci_pkg::result_t res_r;

  assign step = item_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.action;
  assign out_tdata  = {3'd0, res_r.wide_bus, res_r.clock_mode, res_r.card_address,
                       res_r.is_mmc, res_r.delay_first, res_r.long_response,
                       res_r.wait_response, res_r.argument, res_r.cmd_index};

endmodule

// File: rtl/sd_mmc_card_init_sequencer_unit.sv
// Top level of the SD/MMC card init sequencer.
// Path from input transaction to result: input register, then output register.
// Throughput: one event per cycle unless out_tready stalls; decision is combinational.
// Reset: rst_n synchronous, active low; clears phase, counters, card state and both
// stage valids, and loads the attempt limits with 15 (MMC) and 150 (SD).
module sd_mmc_card_init_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sdci_pkg::IN_DATA_W-1:0]  in_tdata,   // timed_out, response[31:0], pad
  input  logic                            in_tuser,   // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sdci_pkg::OUT_DATA_W-1:0] out_tdata,  // cmd_index[5:0], argument[31:0],
                                                      // wait_response, long_response,
                                                      // delay_first, is_mmc,
                                                      // card_address[15:0], clock_mode[1:0],
                                                      // wide_bus, pad
  output logic [1:0]                      out_tuser,  // action
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [sdci_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              step;
  logic              item_valid;
  sdci_pkg::item_t   item;
  sdci_pkg::result_t res;

  sdci_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .step       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  sdci_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .res       (res)
  );

  sdci_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .step       (step),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/sdci_checker.sv
// Port-level checker for the card init sequencer, bound to the top level.
module sdci_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sdci_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);

  a_rst_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != sdci_pkg::ACT_ISSUE |-> out_tdata[40:0] == 41'd0)
    else $error("command fields set without issue");

  a_clk_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[59:58] != 2'd3)
    else $error("bad clock mode");

  a_wide_sd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[60] |-> !out_tdata[41])
    else $error("wide bus reported for MMC");

endmodule

bind sd_mmc_card_init_sequencer_unit sdci_checker u_sdci_checker (.*);

// File: bench/tb_top.sv
// Self-checking testbench for the SD/MMC card init sequencer: stream-driven events vs. a local model.
`timescale 1ns / 1ps

module tb_top;
  import sdci_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sd_mmc_card_init_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // sequencer model state
  logic [7:0]  mmc_limit = MMC_LIMIT_RST;
  logic [7:0]  sd_limit  = SD_LIMIT_RST;
  phase_t      phase     = PH_IDLE;
  logic [7:0]  tries     = '0;
  logic        card_mmc  = 1'b0;
  logic [15:0] rca       = '0;
  clk_mode_t   clk_sel   = CLK_IDENT;
  logic        inited    = 1'b0;

  result_t queued_commands[$];
  int      errors      = 0;
  int      events_sent = 0;
  int      calm_left   = 0;
  int      idle_cycles = 0;

  function automatic result_t form_result(action_t act, logic [5:0] idx, logic [31:0] arg,
                                          logic w, logic lr, logic dly);
    result_t r;
    r.action        = act;
    r.cmd_index     = idx;
    r.argument      = arg;
    r.wait_response = w;
    r.long_response = lr;
    r.delay_first   = dly;
    r.is_mmc        = card_mmc;
    r.card_address  = rca;
    r.clock_mode    = clk_sel;
    r.wide_bus      = (phase == PH_BUS_APP || phase == PH_BUS_WIDTH || inited) && !card_mmc;
    return r;
  endfunction

  function automatic result_t status(action_t act);
    return form_result(act, '0, '0, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic result_t issue_cmd(logic [5:0] idx, logic [31:0] arg, logic lr,
                                        logic dly);
    return form_result(ACT_ISSUE, idx, arg, 1'b1, lr, dly);
  endfunction

  function automatic result_t enter_sd();
    tries = '0;
    if (sd_limit == 8'd0) begin
      phase = PH_IDLE;
      return status(ACT_FAIL);
    end
    phase = PH_SD_APP;
    return issue_cmd(CMD_APP, {rca, 16'h0000}, 1'b0, 1'b0);
  endfunction

  function automatic result_t enter_cid(logic mmc);
    card_mmc = mmc;
    phase = PH_CID;
    return issue_cmd(CMD_ALL_CID, '0, 1'b1, 1'b0);
  endfunction

  function automatic result_t enter_bus();
    phase = PH_BUS_APP;
    return issue_cmd(CMD_APP, {rca, 16'h0000}, 1'b0, 1'b0);
  endfunction

  task automatic plan_next_command(input op_t op, input logic to, input logic [31:0] rsp);
    result_t r;
    if (op == OP_START) begin
      if (inited) r = status(ACT_OK);
      else if (phase != PH_IDLE) r = status(ACT_NONE);
      else begin
        rca = '0;
        clk_sel = CLK_IDENT;
        tries = '0;
        phase = PH_GO_IDLE;
        r = form_result(ACT_ISSUE, CMD_GO_IDLE, '0, 1'b0, 1'b0, 1'b0);
      end
    end else begin
      case (phase)
        PH_GO_IDLE: begin
          tries = '0;
          if (mmc_limit == 8'd0) r = enter_sd();
          else begin
            phase = PH_MMC_OCR;
            r = issue_cmd(CMD_SEND_OP, MMC_OCR_ARG, 1'b0, 1'b0);
          end
        end
        PH_MMC_OCR: begin
          if (!to && rsp == MMC_OCR_READY) r = enter_cid(1'b1);
          else begin
            tries = tries + 8'd1;
            if (tries < mmc_limit) r = issue_cmd(CMD_SEND_OP, MMC_OCR_ARG, 1'b0, 1'b0);
            else r = enter_sd();
          end
        end
        PH_SD_APP: begin
          phase = PH_SD_OCR;
          r = issue_cmd(CMD_SD_OP, SD_OCR_ARG, 1'b0, 1'b0);
        end
        PH_SD_OCR: begin
          if (!to && rsp == SD_OCR_READY) r = enter_cid(1'b0);
          else begin
            tries = tries + 8'd1;
            if (tries < sd_limit) begin
              phase = PH_SD_APP;
              r = issue_cmd(CMD_APP, {rca, 16'h0000}, 1'b0, 1'b1);
            end else begin
              phase = PH_IDLE;
              r = status(ACT_FAIL);
            end
          end
        end
        PH_CID: begin
          if (to) r = issue_cmd(CMD_ALL_CID, '0, 1'b1, 1'b0);
          else begin
            phase = PH_RCA;
            r = issue_cmd(CMD_SET_RCA, card_mmc ? MMC_RCA_ARG : 32'h0, 1'b0, 1'b0);
          end
        end
        PH_RCA: begin
          if (to) r = issue_cmd(CMD_SET_RCA, card_mmc ? MMC_RCA_ARG : 32'h0, 1'b0, 1'b0);
          else begin
            if (card_mmc) begin
              rca = MMC_RCA;
              clk_sel = CLK_MMC;
            end else begin
              rca = rsp[31:16];
              clk_sel = CLK_SD;
            end
            phase = PH_SELECT;
            r = issue_cmd(CMD_SELECT, {rca, 16'h0000}, 1'b0, 1'b0);
          end
        end
        PH_SELECT: begin
          if (to) r = issue_cmd(CMD_SELECT, {rca, 16'h0000}, 1'b0, 1'b0);
          else r = enter_bus();
        end
        PH_BUS_APP: begin
          phase = PH_BUS_WIDTH;
          r = issue_cmd(CMD_BUS_WID, card_mmc ? 32'h0 : SD_BUS4_ARG, 1'b0, 1'b0);
        end
        PH_BUS_WIDTH: begin
          if (to) r = enter_bus();
          else begin
            phase = PH_IDLE;
            inited = 1'b1;
            r = status(ACT_OK);
          end
        end
        default: begin
          phase = PH_IDLE;
          r = status(ACT_NONE);
        end
      endcase
    end
    queued_commands.push_back(r);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_left > 0) return 0;
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic push_event(input op_t op, input logic to, input logic [31:0] rsp);
    int gap;
    gap = pick_gap();
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(20, 60);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, rsp, to};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    plan_next_command(op, to, rsp);
    events_sent++;
  endtask

  task automatic push_start();
    push_event(OP_START, 1'($urandom_range(0, 1)), $urandom);
  endtask

  function automatic logic [32:0] ocr_miss(logic [31:0] ready, logic [31:0] wrong);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: return {1'b1, ($urandom_range(0, 1) != 0) ? ready : w};
      1: return {1'b0, ready ^ (32'h1 << $urandom_range(0, 31))};
      2: return {1'b0, wrong};
      default: return {1'b0, (w == ready) ? ~w : w};
    endcase
  endfunction

  // completion that never lets an OCR poll succeed
  task automatic push_not_ready();
    logic [32:0] c;
    if (phase == PH_MMC_OCR) c = ocr_miss(MMC_OCR_READY, SD_OCR_READY);
    else if (phase == PH_SD_OCR) c = ocr_miss(SD_OCR_READY, MMC_OCR_READY);
    else c = {1'($urandom_range(0, 1)), 32'($urandom)};
    push_event(OP_DONE, c[32], c[31:0]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (queued_commands.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MMC_LIMIT) mmc_limit = val;
    else sd_limit = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [7:0] mmc_val, input logic [7:0] sd_val);
    drain();
    write_limit(CFG_MMC_LIMIT, mmc_val);
    write_limit(CFG_SD_LIMIT, sd_val);
  endtask

  task automatic fail_out();
    while (phase != PH_IDLE) push_not_ready();
  endtask

  task automatic test_idle_completions();
    push_event(OP_DONE, 1'b0, 32'h0000_0000);
    push_event(OP_DONE, 1'b1, 32'hffff_ffff);
  endtask

  // reset limits: 15 CMD1 polls, then 150 CMD55/ACMD41 rounds before failing
  task automatic test_reset_limits();
    push_start();
    push_start();
    push_event(OP_DONE, 1'b0, 32'hffff_ffff);
    push_event(OP_DONE, 1'b1, MMC_OCR_READY);
    push_event(OP_DONE, 1'b0, SD_OCR_READY);
    push_event(OP_DONE, 1'b0, MMC_OCR_READY ^ 32'h8000_0000);
    push_start();
    fail_out();
  endtask

  task automatic test_zero_limits();
    set_limits(8'd0, 8'd0);
    push_start();
    push_event(OP_DONE, 1'b0, 32'h0);
    set_limits(8'd0, 8'd1);
    push_start();
    push_event(OP_DONE, 1'b0, 32'h0);
    push_event(OP_DONE, 1'b1, 32'h0);
    push_event(OP_DONE, 1'b1, SD_OCR_READY);
    set_limits(8'd1, 8'd1);
    push_start();
    push_event(OP_DONE, 1'b0, 32'h0);
    push_event(OP_DONE, 1'b0, MMC_OCR_ARG);
    push_event(OP_DONE, 1'b0, 32'h0);
    push_event(OP_DONE, 1'b0, MMC_OCR_READY);
  endtask

  task automatic test_max_limits();
    set_limits(8'd255, 8'd1);
    push_start();
    fail_out();
  endtask

  task automatic test_random_sequences();
    int stop_at;
    stop_at = events_sent + 350;
    while (events_sent < stop_at) begin
      if (phase == PH_IDLE && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) == 0)
          set_limits(8'($urandom_range(0, 40)), 8'($urandom_range(0, 30)));
        else
          set_limits(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
      end
      if ($urandom_range(0, 49) == 0) drain();
      if (phase == PH_IDLE) begin
        if ($urandom_range(0, 99) < 85) push_start();
        else push_not_ready();
      end else if ($urandom_range(0, 99) < 4) push_start();
      else push_not_ready();
    end
    fail_out();
  endtask

  // the one run that gets through: card type picked at random
  task automatic test_bring_up();
    logic want_mmc;
    want_mmc = 1'($urandom_range(0, 1));
    set_limits(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
    push_start();
    while (phase != PH_CID) begin
      if (phase == PH_MMC_OCR && want_mmc &&
          (tries == mmc_limit - 8'd1 || $urandom_range(0, 2) == 0))
        push_event(OP_DONE, 1'b0, MMC_OCR_READY);
      else if (phase == PH_SD_OCR && !want_mmc &&
               (tries == sd_limit - 8'd1 || $urandom_range(0, 2) == 0))
        push_event(OP_DONE, 1'b0, SD_OCR_READY);
      else push_not_ready();
    end
    while (!inited) begin
      if ($urandom_range(0, 19) == 0) push_start();
      else push_event(OP_DONE, 1'($urandom_range(0, 1)), $urandom);
    end
    repeat (3) begin
      push_start();
      push_event(OP_DONE, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  // result side: random stalls
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = (calm_left > 0) ? 0 : pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (queued_commands.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual tuser %0h tdata %0h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = queued_commands.pop_front();
        check_field("action", 32'(want.action), 32'(out_tuser));
        check_field("cmd_index", 32'(want.cmd_index), 32'(out_tdata[5:0]));
        check_field("argument", want.argument, out_tdata[37:6]);
        check_field("wait_response", 32'(want.wait_response), 32'(out_tdata[38]));
        check_field("long_response", 32'(want.long_response), 32'(out_tdata[39]));
        check_field("delay_first", 32'(want.delay_first), 32'(out_tdata[40]));
        check_field("is_mmc", 32'(want.is_mmc), 32'(out_tdata[41]));
        check_field("card_address", 32'(want.card_address), 32'(out_tdata[57:42]));
        check_field("clock_mode", 32'(want.clock_mode), 32'(out_tdata[59:58]));
        check_field("wide_bus", 32'(want.wide_bus), 32'(out_tdata[60]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_completions();
    test_reset_limits();
    test_zero_limits();
    test_max_limits();
    test_random_sequences();
    test_bring_up();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && queued_commands.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
